@@ design/thq_pkg.sv @@
// Shared types and constants of the terrain height query block.
// No dependencies; imported by every module of the block.
package thq_pkg;

	// Fixed field widths.
	localparam int FRAC_BITS = 16;
	localparam int IDX_BITS  = 12;
	localparam int FQ_DEPTH  = 4;
	localparam int FQ_PTR_W  = 2;
	localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

	// Register reset values.
	localparam logic [8:0]  RST_COLUMNS   = 9'd256;
	localparam logic [8:0]  RST_ROWS      = 9'd256;
	localparam logic [15:0] RST_POLY_SIZE = 16'd256;
	localparam logic [15:0] RST_AMPLIFIER = 16'd256;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CFG_COLUMNS   = 2'd0,
		CFG_ROWS      = 2'd1,
		CFG_POLY_SIZE = 2'd2,
		CFG_AMPLIFIER = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [8:0]  grid_columns;
		logic [8:0]  grid_rows;
		logic [15:0] polygon_size;
		logic [15:0] amplifier;
	} cfg_t;

	// Classified transaction handed from the front part to the back part.
	// For a write, in_range means the sample lies inside the store.
	typedef struct packed {
		logic                 query;
		logic                 in_range;
		logic [IDX_BITS-1:0]  col;
		logic [IDX_BITS-1:0]  row;
		logic [7:0]           height;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fz;
	} fq_item_t;

endpackage

@@ design/terrain_height_query_core.sv @@
// Top level of the terrain height query block: configuration registers,
// front part, queue and back part. Depends on thq_pkg, thq_front, thq_fifo, thq_back.

// The block takes one transaction per clock cycle while in_ready is high,
// writes and queries alike, and delivers one query result per cycle while
// out_ready is high; a write gives no result. A query passes one input
// stage, the divider (one quotient bit per stage for both coordinates), the
// four-entry queue and the back part: store read, slope products, plane sum,
// amplifier product and the output register. A write lands in the store when
// it leaves the queue, in order with the queries around it, so a query after
// a write sees it. The store is split into four parity banks with one read
// port each, which is what lets all corners of a cell be read in the same
// cycle. Store entries are not cleared at reset; a query must only touch
// samples that were written. Configuration must be written while no
// transaction is in flight.
module terrain_height_query_core import thq_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int HEIGHT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  write_column,
	input  logic [7:0]  write_row,
	input  logic [7:0]  write_height,
	input  logic signed [24:0] query_x,
	input  logic signed [24:0] query_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] terrain_height,
	output logic        in_range
);

	logic [8:0]  grid_columns_q;
	logic [8:0]  grid_rows_q;
	logic [15:0] polygon_size_q;
	logic [15:0] amplifier_q;
	cfg_t        cfg;
	logic        fq_full;
	logic        fq_push;
	fq_item_t    fq_in;
	logic        fq_pop;
	logic        fq_valid;
	fq_item_t    fq_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= RST_COLUMNS;
			grid_rows_q    <= RST_ROWS;
			polygon_size_q <= RST_POLY_SIZE;
			amplifier_q    <= RST_AMPLIFIER;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COLUMNS:   grid_columns_q <= cfg_data[8:0];
				CFG_ROWS:      grid_rows_q    <= cfg_data[8:0];
				CFG_POLY_SIZE: polygon_size_q <= cfg_data;
				CFG_AMPLIFIER: amplifier_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.grid_columns = grid_columns_q;
	assign cfg.grid_rows    = grid_rows_q;
	assign cfg.polygon_size = polygon_size_q;
	assign cfg.amplifier    = amplifier_q;

	thq_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.write_column(write_column),
		.write_row(write_row),
		.write_height(write_height),
		.query_x(query_x),
		.query_z(query_z),
		.fq_full(fq_full),
		.fq_push(fq_push),
		.fq_item(fq_in)
	);

	thq_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fq_push),
		.push_item(fq_in),
		.full(fq_full),
		.pop(fq_pop),
		.not_empty(fq_valid),
		.head(fq_head)
	);

	thq_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.amplifier(cfg.amplifier),
		.fq_valid(fq_valid),
		.fq_head(fq_head),
		.fq_pop(fq_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.terrain_height(terrain_height),
		.in_range(in_range)
	);

endmodule

@@ design/thq_front.sv @@
// Front part: accepts transactions, divides query coordinates by the cell size
// in a bit-per-stage pipeline and classifies them. Depends on thq_pkg.
module thq_front import thq_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  write_column,
	input  logic [7:0]  write_row,
	input  logic [7:0]  write_height,
	input  logic signed [24:0] query_x,
	input  logic signed [24:0] query_z,
	input  logic        fq_full,
	output logic        fq_push,
	output fq_item_t    fq_item
);

	localparam int CB = $clog2(MAX_COLUMNS);
	localparam int RB = $clog2(MAX_ROWS);
	localparam int SB = (CB > RB) ? CB : RB;
	localparam int QS = SB + FRAC_BITS;

	typedef struct packed {
		logic          query;
		logic          bad;
		logic [7:0]    wcol;
		logic [7:0]    wrow;
		logic [7:0]    wh;
		logic [15:0]   rx;
		logic [15:0]   rz;
		logic [QS-1:0] lx;
		logic [QS-1:0] lz;
		logic [QS-1:0] qx;
		logic [QS-1:0] qz;
	} div_t;

	// One restoring division step per stage for both coordinates.
	function automatic div_t div_step(div_t a, logic [15:0] d);
		div_t o;
		logic [16:0] tx;
		logic [16:0] tz;
		o  = a;
		tx = {a.rx, a.lx[QS-1]};
		tz = {a.rz, a.lz[QS-1]};
		if (tx >= {1'b0, d}) begin
			o.rx = 16'(tx - {1'b0, d});
			o.qx = {a.qx[QS-2:0], 1'b1};
		end else begin
			o.rx = tx[15:0];
			o.qx = {a.qx[QS-2:0], 1'b0};
		end
		if (tz >= {1'b0, d}) begin
			o.rz = 16'(tz - {1'b0, d});
			o.qz = {a.qz[QS-2:0], 1'b1};
		end else begin
			o.rz = tz[15:0];
			o.qz = {a.qz[QS-2:0], 1'b0};
		end
		o.lx = a.lx << 1;
		o.lz = a.lz << 1;
		return o;
	endfunction

	logic [23:0] vx;
	logic [23:0] vz;
	logic [12:0] effc;
	logic [12:0] effr;
	logic [12:0] limc;
	logic [12:0] limr;
	logic        ovx;
	logic        ovz;
	logic        badq;
	logic        wok;
	logic        en;
	logic        accept;
	div_t        in0;
	div_t        pipe_s [QS+1];
	logic [QS:0] vld_s;
	div_t        last;
	logic [SB-1:0] cx;
	logic [SB-1:0] cz;
	logic        qbad;

	// Clipped sample counts and the last legal grid coordinate.
	always_comb begin
		effc = (13'(cfg.grid_columns) > 13'(MAX_COLUMNS)) ?
			13'(MAX_COLUMNS) : 13'(cfg.grid_columns);
		effr = (13'(cfg.grid_rows) > 13'(MAX_ROWS)) ?
			13'(MAX_ROWS) : 13'(cfg.grid_rows);
		limc = effc - 13'd1;
		limr = effr - 13'd1;
	end

	// Classify the incoming transaction and seed the divider.
	always_comb begin
		vx   = query_x[23:0];
		vz   = query_z[23:0];
		ovx  = 40'(vx) >= (40'(cfg.polygon_size) << CB);
		ovz  = 40'(vz) >= (40'(cfg.polygon_size) << RB);
		badq = query_x[24] || query_z[24] || (vx == 24'd0) || (vz == 24'd0) ||
			(cfg.polygon_size == 16'd0) || (effc < 13'd2) || (effr < 13'd2) ||
			ovx || ovz;
		wok  = (13'(write_column) < 13'(MAX_COLUMNS)) &&
			(13'(write_row) < 13'(MAX_ROWS));
		in0.query = (action == ACT_QUERY);
		in0.bad   = (action == ACT_QUERY) ? badq : !wok;
		in0.wcol  = write_column;
		in0.wrow  = write_row;
		in0.wh    = write_height;
		in0.rx    = 16'(vx >> SB);
		in0.rz    = 16'(vz >> SB);
		in0.lx    = {vx[SB-1:0], 16'd0};
		in0.lz    = {vz[SB-1:0], 16'd0};
		in0.qx    = '0;
		in0.qz    = '0;
	end

	// The whole front advances unless its last stage cannot enter the queue.
	assign en       = !vld_s[QS] || !fq_full;
	assign in_ready = en;
	assign accept   = in_valid && en;
	assign fq_push  = vld_s[QS] && !fq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QS-1:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= in0;
		end
	end

	for (genvar k = 1; k <= QS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k] <= div_step(pipe_s[k-1], cfg.polygon_size);
			end
		end
	end

	// Final range check on the quotients and packing of the queue entry.
	always_comb begin
		last = pipe_s[QS];
		cx   = last.qx[QS-1:FRAC_BITS];
		cz   = last.qz[QS-1:FRAC_BITS];
		qbad = (last.qx == '0) || (last.qz == '0) ||
			(13'(cx) >= limc) || (13'(cz) >= limr);
		fq_item.query    = last.query;
		fq_item.in_range = last.query ? !(last.bad || qbad) : !last.bad;
		fq_item.col      = last.query ? IDX_BITS'(cx) : IDX_BITS'(last.wcol);
		fq_item.row      = last.query ? IDX_BITS'(cz) : IDX_BITS'(last.wrow);
		fq_item.height   = last.wh;
		fq_item.fx       = last.qx[FRAC_BITS-1:0];
		fq_item.fz       = last.qz[FRAC_BITS-1:0];
	end

endmodule

@@ design/thq_fifo.sv @@
// Short queue between the front and back parts of the block.
// Depends on thq_pkg.
module thq_fifo import thq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  fq_item_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output fq_item_t head
);

	fq_item_t              ent_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0]   wp_q;
	logic [FQ_PTR_W-1:0]   rp_q;
	logic [FQ_PTR_W:0]     cnt_q;

	assign full      = (cnt_q == (FQ_PTR_W+1)'(FQ_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = ent_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (FQ_PTR_W+1)'(push) - (FQ_PTR_W+1)'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

endmodule

@@ design/thq_back.sv @@
// Back part: four banked height stores, triangle interpolation, amplifier
// scaling and the output register. Depends on thq_pkg.
module thq_back import thq_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int HEIGHT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] amplifier,
	input  logic        fq_valid,
	input  fq_item_t    fq_head,
	output logic        fq_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] terrain_height,
	output logic        in_range
);

	localparam int CW = ($clog2(MAX_COLUMNS) < 2) ? 2 : $clog2(MAX_COLUMNS);
	localparam int RW = ($clog2(MAX_ROWS) < 2) ? 2 : $clog2(MAX_ROWS);
	localparam int CA = CW - 1;
	localparam int RA = RW - 1;
	localparam int AW = CA + RA;
	localparam int HB = HEIGHT_BITS;
	localparam int YW = HB + FRAC_BITS;
	localparam int MW = YW + 16;

	logic               en;
	logic               valid_s1;
	logic               range_s1;
	logic               c0_s1;
	logic               r0_s1;
	logic [15:0]        fx_s1;
	logic [15:0]        fz_s1;
	logic [HB-1:0]      rd_s1 [4];
	logic [HB-1:0]      h00;
	logic [HB-1:0]      h10;
	logic [HB-1:0]      h01;
	logic [HB-1:0]      h11;
	logic               upper;
	logic signed [HB:0] d1;
	logic signed [HB:0] d2;
	logic [15:0]        f1;
	logic [15:0]        f2;
	logic               valid_s2;
	logic               range_s2;
	logic [HB-1:0]      h00_s2;
	logic signed [HB+17:0] p1_s2;
	logic signed [HB+17:0] p2_s2;
	logic signed [HB+18:0] ysum;
	logic               valid_s3;
	logic               range_s3;
	logic [YW-1:0]      y_s3;
	logic               valid_s4;
	logic               range_s4;
	logic [MW-1:0]      m_s4;
	logic [47:0]        mx;
	logic               out_valid_q;
	logic [23:0]        height_q;
	logic               range_q;

	// The back pipeline moves as one unless the output register is held.
	assign en     = !out_valid_q || out_ready;
	assign fq_pop = fq_valid && en;

	// Height store in four banks by column and row parity, so the four
	// corners of a cell always sit in different banks.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam bit XB = (b & 1) != 0;
		localparam bit YB = (b & 2) != 0;

		logic [HB-1:0] mem [2**AW];
		logic [CA-1:0] rca;
		logic [RA-1:0] rra;
		logic          we;
		logic          re;

		always_comb begin
			rca = XB ? fq_head.col[CW-1:1] :
				fq_head.col[CW-1:1] + CA'(fq_head.col[0]);
			rra = YB ? fq_head.row[RW-1:1] :
				fq_head.row[RW-1:1] + RA'(fq_head.row[0]);
			we  = fq_pop && !fq_head.query && fq_head.in_range &&
				(fq_head.col[0] == XB) && (fq_head.row[0] == YB);
			re  = fq_pop && fq_head.query;
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem[{fq_head.row[RW-1:1], fq_head.col[CW-1:1]}] <= HB'(fq_head.height);
			end
			if (re) begin
				rd_s1[b] <= mem[{rra, rca}];
			end
		end
	end

	// Valid bits of all stages: only queries continue past the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= fq_pop && fq_head.query;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			range_s1 <= fq_head.in_range;
			c0_s1    <= fq_head.col[0];
			r0_s1    <= fq_head.row[0];
			fx_s1    <= fq_head.fx;
			fz_s1    <= fq_head.fz;
		end
	end

	// Pick the corners and the triangle, then form the two slope products.
	always_comb begin
		h00   = rd_s1[{r0_s1, c0_s1}];
		h10   = rd_s1[{r0_s1, !c0_s1}];
		h01   = rd_s1[{!r0_s1, c0_s1}];
		h11   = rd_s1[{!r0_s1, !c0_s1}];
		upper = fx_s1 < fz_s1;
		if (upper) begin
			d1 = $signed({1'b0, h01}) - $signed({1'b0, h00});
			d2 = $signed({1'b0, h11}) - $signed({1'b0, h01});
			f1 = fz_s1;
			f2 = fx_s1;
		end else begin
			d1 = $signed({1'b0, h10}) - $signed({1'b0, h00});
			d2 = $signed({1'b0, h11}) - $signed({1'b0, h10});
			f1 = fx_s1;
			f2 = fz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			range_s2 <= range_s1;
			h00_s2   <= h00;
			p1_s2    <= $signed({1'b0, f1}) * d1;
			p2_s2    <= $signed({1'b0, f2}) * d2;
		end
	end

	// Sum on the plane; outside queries and negative sums give zero.
	assign ysum = $signed({3'b000, h00_s2, 16'd0}) + (HB+19)'(p1_s2) + (HB+19)'(p2_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			range_s3 <= range_s2;
			y_s3     <= (!range_s2 || ysum[HB+18]) ? '0 : ysum[YW-1:0];
		end
	end

	// Amplifier scaling.
	always_ff @(posedge clk) begin
		if (en) begin
			range_s4 <= range_s3;
			m_s4     <= MW'(y_s3) * MW'(amplifier);
		end
	end

	// Truncate to Q16.8, saturate, and hold in the output register.
	assign mx = 48'(m_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			range_q  <= range_s4;
			height_q <= (|mx[47:40]) ? OUT_MAX : mx[39:16];
		end
	end

	assign out_valid      = out_valid_q;
	assign terrain_height = height_q;
	assign in_range       = range_q;

endmodule

@@ design/thq_checker.sv @@
// Port-level checker for the terrain height query block, bound to the top level.
// Depends on thq_pkg and terrain_height_query_core.
module thq_checker import thq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] terrain_height,
	input logic        in_range
);

	logic [7:0] pend_q;
	logic       q_acc;
	logic       r_acc;

	assign q_acc = in_valid && in_ready && (action == ACT_QUERY);
	assign r_acc = out_valid && out_ready;

	// Queries accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(q_acc) - 8'(r_acc);
		end
	end

	// A held result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(terrain_height) &&
		$stable(in_range))
		else $error("result changed while stalled");

	// An outside query reports zero height.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> terrain_height == 24'd0)
		else $error("outside query with nonzero height");

	// Every result belongs to an earlier query transaction.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result without pending query");

endmodule

bind terrain_height_query_core thq_checker u_thq_checker (.*);
